// File: design/cma2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cma2d_pkg;

   localparam int CMA2D_HALF_WINDOW = 5;
   localparam int CMA2D_COORD_W     = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_TOUT,
      ST_FRD,
      ST_FOUT
   } cma2d_state_type;

endpackage

`default_nettype wire

// File: design/centered_moving_average_2d_core.sv
// Channel  Direction  Transaction payload
// -------  ---------  -------------------------------------------------------------
// req_     in         tdata = pos_x, pos_y; tlast = last_point
// rsp_     out        tdata = out_x, out_y; tuser = was_averaged; tlast = last_out
//
// An input passes ST_IDLE and ST_CALC, then goes back to ST_IDLE if it gives no
// result; a passed-through point goes on to ST_TOUT. An averaged result passes
// ST_DIV, where the window sum is made a magnitude, multiplied by a scaled
// reciprocal in four partial products, summed and given its sign back. Each flushed
// point is read from the window memory in ST_FRD. Reset is synchronous and leaves
// the block empty and ready. A stalled result holds in the output register and the
// sequencer waits for it before it loads the next one.
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average_2d_core
   import cma2d_pkg::*;
#(
   parameter int HALF_WINDOW = CMA2D_HALF_WINDOW
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // pos_x [31:0], pos_y [63:32]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // out_x [31:0], out_y [63:32]
   output logic             rsp_tuser,   // was_averaged [0]
   output logic             rsp_tlast
);

   localparam int W     = 2 * HALF_WINDOW + 1;
   localparam int PW    = $clog2(W);
   localparam int CW    = $clog2(W + 1);
   localparam int SUM_W = CMA2D_COORD_W + $clog2(W);
   localparam int XW    = SUM_W - CMA2D_COORD_W;
   localparam int MW    = SUM_W + 1;
   localparam int RS    = SUM_W + PW;
   localparam int HD    = (SUM_W + 1) / 2;
   localparam int DHW   = SUM_W - HD;
   localparam int HM    = (MW + 1) / 2;
   localparam int MHW   = MW - HM;
   localparam int PRW   = SUM_W + MW;

   localparam logic [PW-1:0]    PTR_LAST = PW'(W - 1);
   localparam logic [CW-1:0]    CNT_FULL = CW'(W);
   localparam logic [CW-1:0]    CNT_HALF = CW'(HALF_WINDOW);
   localparam logic [SUM_W-1:0] HALF_ADD = SUM_W'(HALF_WINDOW);
   localparam logic [MW-1:0]    RECIP    = MW'(((64'd1 << RS) + 64'(W) - 64'd1) / 64'(W));
   localparam logic [HM-1:0]    RECIP_LO = RECIP[HM-1:0];
   localparam logic [MHW-1:0]   RECIP_HI = RECIP[MW-1:HM];

   localparam logic [1:0] DIV_ABS  = 2'd0;
   localparam logic [1:0] DIV_MUL  = 2'd1;
   localparam logic [1:0] DIV_SUM  = 2'd2;
   localparam logic [1:0] DIV_SIGN = 2'd3;

   cma2d_state_type state_ff, state_in;

   logic [2*CMA2D_COORD_W-1:0] win_mem [W];
   logic [2*CMA2D_COORD_W-1:0] rd_a_ff, rd_b_ff;
   logic                       mem_we;
   logic [PW-1:0]              mem_wa, ra_a, ra_b;

   logic [PW-1:0]            wr_ptr_ff, wr_ptr_in, new_ptr_ff, new_ptr_in;
   logic [PW-1:0]            fl_ptr_ff, fl_ptr_in;
   logic [CW-1:0]            cnt_ff, cnt_in, fl_left_ff, fl_left_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CMA2D_COORD_W-1:0] in_x_ff, in_x_in, in_y_ff, in_y_in;
   logic                     last_ff, last_in;
   logic [CMA2D_COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                     res_avg_ff, res_avg_in;
   logic [SUM_W-1:0]         num_x_ff, num_x_in, num_y_ff, num_y_in;
   logic [HD+HM-1:0]         pp_ll_x_ff, pp_ll_x_in, pp_ll_y_ff, pp_ll_y_in;
   logic [HD+MHW-1:0]        pp_lh_x_ff, pp_lh_x_in, pp_lh_y_ff, pp_lh_y_in;
   logic [DHW+HM-1:0]        pp_hl_x_ff, pp_hl_x_in, pp_hl_y_ff, pp_hl_y_in;
   logic [DHW+MHW-1:0]       pp_hh_x_ff, pp_hh_x_in, pp_hh_y_ff, pp_hh_y_in;
   logic                     neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [1:0]               div_cnt_ff, div_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CMA2D_COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                     rsp_avg_ff, rsp_avg_in, rsp_last_ff, rsp_last_in;

   logic [PW:0]              center_sum, fl_sum;
   logic [PW-1:0]            center_ptr, fl_start, wr_ptr_next, fl_ptr_next;
   logic [CW-1:0]            n_new, fl_base, fl_cnt;
   logic signed [SUM_W-1:0]  sub_x, sub_y, add_x, add_y, sum_x_new, sum_y_new;
   logic [SUM_W-1:0]         dvd_x, dvd_y;
   logic [PRW-1:0]           prod_x, prod_y;
   logic                     out_free;

   // Window memory: one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_wa] <= {in_y_in, in_x_in};
      end
      rd_a_ff <= win_mem[ra_a];
      rd_b_ff <= win_mem[ra_b];
   end

   assign center_sum  = {1'b0, wr_ptr_ff} + (PW + 1)'(HALF_WINDOW + 1);
   assign center_ptr  = (center_sum >= (PW + 1)'(W)) ? PW'(center_sum - (PW + 1)'(W))
                                                     : center_sum[PW-1:0];
   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign fl_ptr_next = (fl_ptr_ff == PTR_LAST) ? '0 : fl_ptr_ff + 1'b1;

   assign n_new = (cnt_ff == CNT_FULL) ? cnt_ff : cnt_ff + 1'b1;

   assign sub_x = (cnt_ff == CNT_FULL) ? {{XW{rd_a_ff[31]}}, rd_a_ff[31:0]} : '0;
   assign sub_y = (cnt_ff == CNT_FULL) ? {{XW{rd_a_ff[63]}}, rd_a_ff[63:32]} : '0;
   assign add_x = {{XW{in_x_ff[31]}}, in_x_ff};
   assign add_y = {{XW{in_y_ff[31]}}, in_y_ff};
   assign sum_x_new = sum_x_ff - sub_x + add_x;
   assign sum_y_new = sum_y_ff - sub_y + add_y;

   // The rounded mean magnitude is (|sum| + HALF_WINDOW) / W, taken as a product
   // with a scaled reciprocal of W that is split into four partial products.
   assign dvd_x = sum_x_ff[SUM_W-1] ? HALF_ADD - $unsigned(sum_x_ff)
                                    : $unsigned(sum_x_ff) + HALF_ADD;
   assign dvd_y = sum_y_ff[SUM_W-1] ? HALF_ADD - $unsigned(sum_y_ff)
                                    : $unsigned(sum_y_ff) + HALF_ADD;
   assign prod_x = PRW'(pp_ll_x_ff) + (PRW'(pp_lh_x_ff) << HM) + (PRW'(pp_hl_x_ff) << HD)
                   + (PRW'(pp_hh_x_ff) << (HD + HM));
   assign prod_y = PRW'(pp_ll_y_ff) + (PRW'(pp_lh_y_ff) << HM) + (PRW'(pp_hl_y_ff) << HD)
                   + (PRW'(pp_hh_y_ff) << (HD + HM));

   // The flush covers at most HALF_WINDOW points, ending at the newest one.
   assign fl_base  = (state_ff == ST_CALC) ? n_new : cnt_ff;
   assign fl_cnt   = (fl_base > CNT_HALF) ? CNT_HALF : fl_base;
   assign fl_sum   = {1'b0, new_ptr_ff} + (PW + 1)'(W) - (PW + 1)'(fl_cnt - 1'b1);
   assign fl_start = (fl_sum >= (PW + 1)'(W)) ? PW'(fl_sum - (PW + 1)'(W))
                                              : fl_sum[PW-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      new_ptr_in   = new_ptr_ff;
      fl_ptr_in    = fl_ptr_ff;
      fl_left_in   = fl_left_ff;
      cnt_in       = cnt_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      in_x_in      = in_x_ff;
      in_y_in      = in_y_ff;
      last_in      = last_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_avg_in   = res_avg_ff;
      num_x_in     = num_x_ff;
      num_y_in     = num_y_ff;
      pp_ll_x_in   = pp_ll_x_ff;
      pp_ll_y_in   = pp_ll_y_ff;
      pp_lh_x_in   = pp_lh_x_ff;
      pp_lh_y_in   = pp_lh_y_ff;
      pp_hl_x_in   = pp_hl_x_ff;
      pp_hl_y_in   = pp_hl_y_ff;
      pp_hh_x_in   = pp_hh_x_ff;
      pp_hh_y_in   = pp_hh_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = wr_ptr_ff;
      ra_a         = wr_ptr_ff;
      ra_b         = center_ptr;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               in_x_in    = req_tdata[31:0];
               in_y_in    = req_tdata[63:32];
               last_in    = req_tlast;
               mem_we     = 1'b1;
               new_ptr_in = wr_ptr_ff;
               wr_ptr_in  = wr_ptr_next;
               state_in   = ST_CALC;
            end
         end
         ST_CALC: begin
            sum_x_in = sum_x_new;
            sum_y_in = sum_y_new;
            cnt_in   = n_new;
            if (n_new > CNT_HALF) begin
               if (n_new == CNT_FULL) begin
                  neg_x_in   = sum_x_new[SUM_W-1];
                  neg_y_in   = sum_y_new[SUM_W-1];
                  div_cnt_in = DIV_ABS;
                  state_in   = ST_DIV;
               end else begin
                  res_x_in   = rd_b_ff[31:0];
                  res_y_in   = rd_b_ff[63:32];
                  res_avg_in = 1'b0;
                  state_in   = ST_TOUT;
               end
            end else if (last_ff) begin
               fl_ptr_in  = fl_start;
               fl_left_in = fl_cnt;
               state_in   = ST_FRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            case (div_cnt_ff)
               DIV_ABS: begin
                  num_x_in   = dvd_x;
                  num_y_in   = dvd_y;
                  div_cnt_in = DIV_MUL;
               end
               DIV_MUL: begin
                  pp_ll_x_in = (HD + HM)'(num_x_ff[HD-1:0]) * (HD + HM)'(RECIP_LO);
                  pp_ll_y_in = (HD + HM)'(num_y_ff[HD-1:0]) * (HD + HM)'(RECIP_LO);
                  pp_lh_x_in = (HD + MHW)'(num_x_ff[HD-1:0]) * (HD + MHW)'(RECIP_HI);
                  pp_lh_y_in = (HD + MHW)'(num_y_ff[HD-1:0]) * (HD + MHW)'(RECIP_HI);
                  pp_hl_x_in = (DHW + HM)'(num_x_ff[SUM_W-1:HD]) * (DHW + HM)'(RECIP_LO);
                  pp_hl_y_in = (DHW + HM)'(num_y_ff[SUM_W-1:HD]) * (DHW + HM)'(RECIP_LO);
                  pp_hh_x_in = (DHW + MHW)'(num_x_ff[SUM_W-1:HD]) * (DHW + MHW)'(RECIP_HI);
                  pp_hh_y_in = (DHW + MHW)'(num_y_ff[SUM_W-1:HD]) * (DHW + MHW)'(RECIP_HI);
                  div_cnt_in = DIV_SUM;
               end
               DIV_SUM: begin
                  res_x_in   = prod_x[RS +: CMA2D_COORD_W];
                  res_y_in   = prod_y[RS +: CMA2D_COORD_W];
                  div_cnt_in = DIV_SIGN;
               end
               default: begin
                  res_x_in   = neg_x_ff ? -res_x_ff : res_x_ff;
                  res_y_in   = neg_y_ff ? -res_y_ff : res_y_ff;
                  res_avg_in = 1'b1;
                  state_in   = ST_TOUT;
               end
            endcase
         end
         ST_TOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_avg_in   = res_avg_ff;
               rsp_last_in  = 1'b0;
               if (last_ff) begin
                  fl_ptr_in  = fl_start;
                  fl_left_in = fl_cnt;
                  state_in   = ST_FRD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FRD: begin
            ra_a     = fl_ptr_ff;
            state_in = ST_FOUT;
         end
         ST_FOUT: begin
            ra_a = fl_ptr_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = rd_a_ff[31:0];
               rsp_y_in     = rd_a_ff[63:32];
               rsp_avg_in   = 1'b0;
               rsp_last_in  = (fl_left_ff == CW'(1));
               fl_ptr_in    = fl_ptr_next;
               fl_left_in   = fl_left_ff - 1'b1;
               if (fl_left_ff == CW'(1)) begin
                  cnt_in    = '0;
                  sum_x_in  = '0;
                  sum_y_in  = '0;
                  wr_ptr_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_FRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         cnt_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         cnt_ff       <= cnt_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ptr_ff  <= new_ptr_in;
      fl_ptr_ff   <= fl_ptr_in;
      fl_left_ff  <= fl_left_in;
      in_x_ff     <= in_x_in;
      in_y_ff     <= in_y_in;
      last_ff     <= last_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_avg_ff  <= res_avg_in;
      num_x_ff    <= num_x_in;
      num_y_ff    <= num_y_in;
      pp_ll_x_ff  <= pp_ll_x_in;
      pp_ll_y_ff  <= pp_ll_y_in;
      pp_lh_x_ff  <= pp_lh_x_in;
      pp_lh_y_ff  <= pp_lh_y_in;
      pp_hl_x_ff  <= pp_hl_x_in;
      pp_hl_y_ff  <= pp_hl_y_in;
      pp_hh_x_ff  <= pp_hh_x_in;
      pp_hh_y_ff  <= pp_hh_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_avg_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cma2d_pkg::*;

   localparam int HALF = CMA2D_HALF_WINDOW;
   localparam int SPAN = 2 * HALF + 1;
   localparam int RANDOM_POINTS = 120;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        averaged;
      logic        last;
   } smoothed_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   smoothed_point_type pending_points[$];
   smoothed_point_type oldest_point;

   logic signed [31:0] window_x[SPAN];
   logic signed [31:0] window_y[SPAN];
   logic signed [35:0] run_sum_x = '0;
   logic signed [35:0] run_sum_y = '0;
   logic [15:0]        points_in_sequence = '0;

   int mismatch_count = 0;
   int points_sent = 0;
   int sequences_sent = 0;
   int results_checked = 0;
   int averaged_checked = 0;
   int burst_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   int ready_phase = 0;

   centered_moving_average_2d_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [31:0] rounded_mean(input logic signed [35:0] total);
      logic [35:0] mag;
      logic [37:0] quotient;
      mag = (total < 0) ? 36'(-total) : 36'(total);
      quotient = (38'(mag) * 38'd2 + 38'(SPAN)) / 38'(2 * SPAN);
      return (total < 0) ? -$signed(quotient[31:0]) : $signed(quotient[31:0]);
   endfunction

   function automatic void add_expected(input logic [31:0] x, input logic [31:0] y,
                                        input logic averaged, input logic last);
      smoothed_point_type item;
      item.x        = x;
      item.y        = y;
      item.averaged = averaged;
      item.last     = last;
      pending_points.insert(pending_points.size(), item);
   endfunction

   task automatic smooth_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic last);
      int top;
      if (points_in_sequence >= SPAN) begin
         run_sum_x = run_sum_x - window_x[SPAN-1];
         run_sum_y = run_sum_y - window_y[SPAN-1];
      end
      for (int k = SPAN - 1; k > 0; k--) begin
         window_x[k] = window_x[k-1];
         window_y[k] = window_y[k-1];
      end
      window_x[0] = x;
      window_y[0] = y;
      run_sum_x = run_sum_x + x;
      run_sum_y = run_sum_y + y;
      if (points_in_sequence != 16'hFFFF) begin
         points_in_sequence = points_in_sequence + 16'd1;
      end
      if (points_in_sequence > HALF) begin
         if (points_in_sequence >= SPAN) begin
            add_expected(rounded_mean(run_sum_x), rounded_mean(run_sum_y), 1'b1, 1'b0);
         end else begin
            add_expected(window_x[HALF], window_y[HALF], 1'b0, 1'b0);
         end
      end
      if (last) begin
         top = (points_in_sequence > HALF) ? HALF - 1 : int'(points_in_sequence) - 1;
         for (int k = top; k >= 0; k--) begin
            add_expected(window_x[k], window_y[k], 1'b0, k == 0);
         end
         run_sum_x = '0;
         run_sum_y = '0;
         points_in_sequence = '0;
      end
   endtask

   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 2);
            2: gap = $urandom_range(1, 8);
            default: gap = $urandom_range(10, 30);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= {$urandom, $urandom};
            req_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      smooth_point(x, y, last);
      points_sent++;
      burst_left--;
      if (last) begin
         sequences_sent++;
      end
   endtask

   task automatic send_sequence(input int count, input int style);
      logic signed [31:0] x;
      logic signed [31:0] y;
      x = $urandom;
      y = $urandom;
      for (int i = 0; i < count; i++) begin
         case (style)
            0: begin
               x = $urandom;
               y = $urandom;
            end
            1: begin
               x = $signed($urandom_range(0, 4000)) - 2000;
               y = $signed($urandom_range(0, 4000)) - 2000;
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: x = COORD_MAX;
                  1: x = COORD_MIN;
                  2: x = 0;
                  default: x = -1;
               endcase
               case ($urandom_range(0, 3))
                  0: y = COORD_MAX;
                  1: y = COORD_MIN;
                  2: y = 0;
                  default: y = -1;
               endcase
            end
            default: begin
               x = x + $signed($urandom_range(0, 2048)) - 1024;
               y = y + $signed($urandom_range(0, 2048)) - 1024;
            end
         endcase
         send_point(x, y, i == count - 1);
      end
   endtask

   task automatic test_short_sequences();
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      for (int i = 0; i < HALF; i++) begin
         send_point(32'(i * 1000 - 2000), 32'(7 - i * 3), i == HALF - 1);
      end
      for (int i = 0; i <= HALF; i++) begin
         send_point(-32'(i + 1), 32'(i * 65536), i == HALF);
      end
   endtask

   task automatic test_extreme_windows();
      for (int i = 0; i < SPAN + 2; i++) begin
         if (i < SPAN) begin
            send_point(COORD_MAX, COORD_MIN, 1'b0);
         end else begin
            send_point(COORD_MIN, COORD_MAX, i == SPAN + 1);
         end
      end
   endtask

   task automatic test_random_sequences();
      int count;
      int start;
      start = points_sent;
      while (points_sent - start < RANDOM_POINTS) begin
         if ($urandom_range(0, 9) < 7) begin
            count = $urandom_range(12, 40);
         end else begin
            count = $urandom_range(1, SPAN);
         end
         send_sequence(count, $urandom_range(0, 3));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_phase++;
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (ready_phase % 7) > 2;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected transaction at %0t: x %h y %h averaged %0d last %0d",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser, rsp_tlast);
            end
         end else begin
            oldest_point = pending_points.pop_front();
            results_checked++;
            if (rsp_tuser) begin
               averaged_checked++;
            end
            if (rsp_tdata[31:0] !== oldest_point.x || rsp_tdata[63:32] !== oldest_point.y ||
                rsp_tuser !== oldest_point.averaged || rsp_tlast !== oldest_point.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at %0t: x %h/%h y %h/%h averaged %0d/%0d last %0d/%0d",
                           $time, oldest_point.x, rsp_tdata[31:0], oldest_point.y,
                           rsp_tdata[63:32], oldest_point.averaged, rsp_tuser,
                           oldest_point.last, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_short_sequences();
      test_extreme_windows();
      test_random_sequences();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d points in %0d sequences, from single points to full windows.",
               points_sent, sequences_sent);
      $display("Checked %0d results, %0d of them window averages.", results_checked,
               averaged_checked);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timed out with %0d results outstanding.", pending_points.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
design/cma2d_pkg.sv
design/centered_moving_average_2d_core.sv
tb/sv/tb_top.sv
